FILE: src/border_pad_texel_checker_macros.svh
// ----------------------------------------------------------------------------
// border_pad_texel_checker_macros.svh
// Assertion macros shared by the border pad texel checker RTL.
// ----------------------------------------------------------------------------
`ifndef BORDER_PAD_TEXEL_CHECKER_MACROS_SVH
`define BORDER_PAD_TEXEL_CHECKER_MACROS_SVH

// Same-cycle implication, clocked on aclk, off during reset
`define BPT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on aclk, off during reset
`define BPT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/bpt_pkg.sv
// ----------------------------------------------------------------------------
// bpt_pkg
// Types and constants for the border pad texel checker.
// ----------------------------------------------------------------------------
package bpt_pkg;

    // Field and register widths
    localparam int HALF_W      = 16;
    localparam int CFG_DIM_W   = 12;
    localparam int CFG_POS_W   = 11;
    localparam int CNT_W       = 23;
    localparam int SUM_W       = 63;
    localparam int IN_DATA_W   = 64;
    localparam int OUT_DATA_W  = 312;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 12;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_REGION_X      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_REGION_Y      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_REGION_WIDTH  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_REGION_HEIGHT = 3'd5;

    // Pad side of a texel
    typedef enum logic [1:0] {
        SIDE_TOP,
        SIDE_BOTTOM,
        SIDE_LEFT,
        SIDE_RIGHT
    } side_t;

    // Configuration register set
    typedef struct packed {
        logic [CFG_DIM_W-1:0] image_width;
        logic [CFG_DIM_W-1:0] image_height;
        logic [CFG_POS_W-1:0] region_x;
        logic [CFG_POS_W-1:0] region_y;
        logic [CFG_DIM_W-1:0] region_width;
        logic [CFG_DIM_W-1:0] region_height;
    } cfg_t;

    // Per-texel evaluation result
    typedef struct packed {
        logic                    pad;
        logic                    changed;
        side_t                   side;
        logic signed [SUM_W-1:0] fixed_red;
        logic signed [SUM_W-1:0] fixed_green;
        logic signed [SUM_W-1:0] fixed_blue;
    } eval_t;

endpackage

FILE: src/bpt_texel_eval.sv
// ----------------------------------------------------------------------------
// bpt_texel_eval
// Classifies one texel against the inner region and converts its RGB halves
// to signed fixed point with 24 fractional bits.
// ----------------------------------------------------------------------------
module bpt_texel_eval (
    input  logic [bpt_pkg::IN_DATA_W-1:0] texel,   // red, green, blue, alpha
    input  logic [bpt_pkg::CFG_DIM_W-1:0] col_pos,
    input  logic [bpt_pkg::CFG_DIM_W-1:0] row_pos,
    input  bpt_pkg::cfg_t                 cfg,
    output bpt_pkg::eval_t                result
);
    import bpt_pkg::*;

    localparam int FIX_MAG_W = 40;
    localparam logic [4:0]  HALF_EXP_MAX = 5'h1f;
    localparam logic [HALF_W-1:0] HALF_ONE  = 16'h3C00;
    localparam logic [HALF_W-1:0] HALF_ZERO = 16'h0000;
    localparam logic [FIX_MAG_W-1:0] INF_FIXED = 40'd65504 << 24;

    // Half pattern to two's complement fixed point, 24 fractional bits
    function automatic logic signed [SUM_W-1:0] half_to_fixed(input logic [HALF_W-1:0] h);
        logic [4:0]           e;
        logic [9:0]           m;
        logic [FIX_MAG_W-1:0] mag;
        logic [SUM_W-1:0]     ext;
        e = h[14:10];
        m = h[9:0];
        if (e == 5'd0) begin
            mag = FIX_MAG_W'(m);
        end else if (e == HALF_EXP_MAX) begin
            mag = (m != 10'd0) ? '0 : INF_FIXED;
        end else begin
            mag = FIX_MAG_W'({1'b1, m}) << (e - 5'd1);
        end
        ext = SUM_W'(mag);
        if (h[15]) begin
            ext = -ext;
        end
        return signed'(ext);
    endfunction

    logic [HALF_W-1:0]      red, green, blue, alpha;
    logic [CFG_DIM_W:0]     x1, y1;
    logic [CFG_DIM_W:0]     x_ext, y_ext;
    logic                   in_region, magenta;

    assign red   = texel[15:0];
    assign green = texel[31:16];
    assign blue  = texel[47:32];
    assign alpha = texel[63:48];

    // Region bounds at full register width
    assign x1    = (CFG_DIM_W+1)'(cfg.region_x) + (CFG_DIM_W+1)'(cfg.region_width);
    assign y1    = (CFG_DIM_W+1)'(cfg.region_y) + (CFG_DIM_W+1)'(cfg.region_height);
    assign x_ext = (CFG_DIM_W+1)'(col_pos);
    assign y_ext = (CFG_DIM_W+1)'(row_pos);

    assign in_region = (x_ext >= (CFG_DIM_W+1)'(cfg.region_x)) && (x_ext < x1) &&
                       (y_ext >= (CFG_DIM_W+1)'(cfg.region_y)) && (y_ext < y1);

    assign magenta = (red == HALF_ONE) && (green == HALF_ZERO) &&
                     (blue == HALF_ONE) && (alpha == HALF_ONE);

    // Classify and convert
    always_comb begin
        result.pad         = !in_region;
        result.changed     = !in_region && !magenta;
        if (y_ext < (CFG_DIM_W+1)'(cfg.region_y)) begin
            result.side = SIDE_TOP;
        end else if (y_ext >= y1) begin
            result.side = SIDE_BOTTOM;
        end else if (x_ext < (CFG_DIM_W+1)'(cfg.region_x)) begin
            result.side = SIDE_LEFT;
        end else begin
            result.side = SIDE_RIGHT;
        end
        result.fixed_red   = half_to_fixed(red);
        result.fixed_green = half_to_fixed(green);
        result.fixed_blue  = half_to_fixed(blue);
    end

endmodule

FILE: src/border_pad_texel_checker.sv
// ----------------------------------------------------------------------------
// border_pad_texel_checker
// Scans a frame of half-float RGBA texels, counts pad texels outside the inner
// region, classifies changed (non-magenta) pad texels by side and sums their
// RGB values; emits one result item per frame.
// ----------------------------------------------------------------------------
// Result path: the last texel of a frame is held in the input register, then
//   its frame result is loaded into the result register.
// Throughput: one texel per cycle; the input side stalls only at a frame end
//   while the previous frame's result is still waiting in the result register.
// Reset (aresetn low, synchronous): configuration returns to a full
//   2048x2048 image with a full-size region, position and totals clear.
module border_pad_texel_checker #(
    parameter int MAX_DIM = 2048
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input texels
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [15:0] red_half, [31:16] green_half, [47:32] blue_half, [63:48] alpha_half
    input  logic [bpt_pkg::IN_DATA_W-1:0]   s_tdata,
    // Frame results
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [22:0] pad_total, [45:23] top_changed, [68:46] bottom_changed,
    // [91:69] left_changed, [114:92] right_changed, [177:115] red_sum,
    // [240:178] green_sum, [303:241] blue_sum, [304] pad_untouched
    output logic [bpt_pkg::OUT_DATA_W-1:0]  m_tdata,
    // Configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bpt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bpt_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bpt_pkg::*;

`include "border_pad_texel_checker_macros.svh"

    localparam int POS_W = $clog2(MAX_DIM);
    localparam logic [CFG_DIM_W-1:0] MAX_DIM_C = CFG_DIM_W'(MAX_DIM);
    localparam int PACK_PAD_W = OUT_DATA_W - (5 * CNT_W + 3 * SUM_W + 1);

    cfg_t                    cfg_reg;
    logic                    in_valid_reg;
    logic [IN_DATA_W-1:0]    texel_reg;
    logic [POS_W-1:0]        col_reg, col_next;
    logic [POS_W-1:0]        row_reg, row_next;
    logic [CNT_W-1:0]        pad_count_reg, pad_count_next, pad_count_upd;
    logic [CNT_W-1:0]        side_count_reg  [4];
    logic [CNT_W-1:0]        side_count_next [4];
    logic [CNT_W-1:0]        side_count_upd  [4];
    logic [SUM_W-1:0]        sum_reg  [3];
    logic [SUM_W-1:0]        sum_next [3];
    logic [SUM_W-1:0]        sum_upd  [3];
    logic                    out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0]   out_data_reg;
    logic [OUT_DATA_W-1:0]   out_data_next;

    logic [CFG_DIM_W-1:0]    w_eff, h_eff;
    logic [CFG_DIM_W-1:0]    col_ext, row_ext;
    logic                    row_end, frame_end, advance, out_load, untouched;
    eval_t                   ev;

    // Configuration port always takes writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.image_width   <= 12'd2048;
            cfg_reg.image_height  <= 12'd2048;
            cfg_reg.region_x      <= '0;
            cfg_reg.region_y      <= '0;
            cfg_reg.region_width  <= 12'd2048;
            cfg_reg.region_height <= 12'd2048;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:   cfg_reg.image_width   <= cfg_data;
                REG_IMAGE_HEIGHT:  cfg_reg.image_height  <= cfg_data;
                REG_REGION_X:      cfg_reg.region_x      <= cfg_data[CFG_POS_W-1:0];
                REG_REGION_Y:      cfg_reg.region_y      <= cfg_data[CFG_POS_W-1:0];
                REG_REGION_WIDTH:  cfg_reg.region_width  <= cfg_data;
                REG_REGION_HEIGHT: cfg_reg.region_height <= cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp dimensions to 1..MAX_DIM
    assign w_eff = (cfg_reg.image_width == '0) ? CFG_DIM_W'(1) :
                   (cfg_reg.image_width > MAX_DIM_C) ? MAX_DIM_C : cfg_reg.image_width;
    assign h_eff = (cfg_reg.image_height == '0) ? CFG_DIM_W'(1) :
                   (cfg_reg.image_height > MAX_DIM_C) ? MAX_DIM_C : cfg_reg.image_height;

    assign col_ext = CFG_DIM_W'(col_reg);
    assign row_ext = CFG_DIM_W'(row_reg);

    assign row_end   = ((CFG_DIM_W+1)'(col_ext) + (CFG_DIM_W+1)'(1)) >= (CFG_DIM_W+1)'(w_eff);
    assign frame_end = row_end &&
                       (((CFG_DIM_W+1)'(row_ext) + (CFG_DIM_W+1)'(1)) >= (CFG_DIM_W+1)'(h_eff));

    // Handshake: hold the texel only when a frame result cannot be placed
    assign advance  = in_valid_reg && (!frame_end || !out_valid_reg || m_tready);
    assign out_load = advance && frame_end;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            texel_reg <= s_tdata;
        end
    end

    bpt_texel_eval u_eval (
        .texel   (texel_reg),
        .col_pos (col_ext),
        .row_pos (row_ext),
        .cfg     (cfg_reg),
        .result  (ev)
    );

    // Update counters and sums for the current texel
    always_comb begin
        pad_count_upd = ev.pad ? (pad_count_reg + CNT_W'(1)) : pad_count_reg;
        for (int i = 0; i < 4; i++) begin
            side_count_upd[i] = (ev.changed && (ev.side == side_t'(i))) ?
                                (side_count_reg[i] + CNT_W'(1)) : side_count_reg[i];
        end
        sum_upd[0] = ev.changed ? (sum_reg[0] + ev.fixed_red)   : sum_reg[0];
        sum_upd[1] = ev.changed ? (sum_reg[1] + ev.fixed_green) : sum_reg[1];
        sum_upd[2] = ev.changed ? (sum_reg[2] + ev.fixed_blue)  : sum_reg[2];
    end

    // Advance position; clear everything at frame end
    always_comb begin
        col_next       = col_reg;
        row_next       = row_reg;
        pad_count_next = pad_count_reg;
        side_count_next = side_count_reg;
        sum_next       = sum_reg;
        if (advance) begin
            if (frame_end) begin
                col_next       = '0;
                row_next       = '0;
                pad_count_next = '0;
                for (int i = 0; i < 4; i++) begin
                    side_count_next[i] = '0;
                end
                for (int c = 0; c < 3; c++) begin
                    sum_next[c] = '0;
                end
            end else begin
                if (row_end) begin
                    col_next = '0;
                    row_next = row_reg + POS_W'(1);
                end else begin
                    col_next = col_reg + POS_W'(1);
                end
                pad_count_next  = pad_count_upd;
                side_count_next = side_count_upd;
                sum_next        = sum_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            row_reg       <= '0;
            pad_count_reg <= '0;
            for (int i = 0; i < 4; i++) begin
                side_count_reg[i] <= '0;
            end
            for (int c = 0; c < 3; c++) begin
                sum_reg[c] <= '0;
            end
        end else begin
            col_reg        <= col_next;
            row_reg        <= row_next;
            pad_count_reg  <= pad_count_next;
            side_count_reg <= side_count_next;
            sum_reg        <= sum_next;
        end
    end

    // Pack the frame result from the updated totals
    assign untouched = (side_count_upd[0] == '0) && (side_count_upd[1] == '0) &&
                       (side_count_upd[2] == '0) && (side_count_upd[3] == '0);

    assign out_data_next = {PACK_PAD_W'(0), untouched,
                            sum_upd[2], sum_upd[1], sum_upd[0],
                            side_count_upd[SIDE_RIGHT], side_count_upd[SIDE_LEFT],
                            side_count_upd[SIDE_BOTTOM], side_count_upd[SIDE_TOP],
                            pad_count_upd};

    // Result register: load at frame end, drop when taken
    always_comb begin
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Checks
    `BPT_ASSERT_NOW(a_stall_only_on_full_out, in_valid_reg && !advance, out_valid_reg && !m_tready, "texel held without a waiting result")
    `BPT_ASSERT_NEXT(a_clear_after_frame, out_load, (col_reg == '0) && (row_reg == '0) && (pad_count_reg == '0), "state not cleared after frame end")
    `BPT_ASSERT_NOW(a_sides_within_pad, 1'b1, (25'(side_count_reg[0]) + 25'(side_count_reg[1]) + 25'(side_count_reg[2]) + 25'(side_count_reg[3])) <= 25'(pad_count_reg), "changed count exceeds pad count")

endmodule
